// ===== hw/rtl/quaternion_trs_to_matrix_assert.svh =====
// Assertion macros used by the top module of the quaternion to matrix block.
// They expand to nothing when the code is built for synthesis.
`ifndef QUATERNION_TRS_TO_MATRIX_ASSERT_SVH
`define QUATERNION_TRS_TO_MATRIX_ASSERT_SVH
`ifndef SYNTHESIS
`define QTM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qtm: same-cycle assertion failed");
`define QTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qtm: next-cycle assertion failed");
`else
`define QTM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define QTM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/qtm_pkg.sv =====
`default_nettype none
package qtm_pkg;

  // 1.0 in the Q.28 format of the rotation entries.
  localparam logic signed [33:0] ONE_Q28  = 34'sd268435456;
  // Half an output LSB at 36 fractional bits.
  localparam logic signed [49:0] RND_HALF = 50'sd524288;
  localparam int unsigned        RND_SHIFT = 20;
  // 1.0 in Q15.16.
  localparam logic signed [31:0] ONE_Q16  = 32'sd65536;

  typedef struct packed {
    logic               node;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic [2:0][15:0]   scale;
    logic [2:0][31:0]   trans;
  } in_t;

  typedef struct packed {
    logic               node;
    logic [2:0][15:0]   scale;
    logic [2:0][31:0]   trans;
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] zz;
    logic signed [31:0] xy;
    logic signed [31:0] xz;
    logic signed [31:0] yz;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
  } prod_t;

  // Rotation entries in column-major order: r00 r10 r20 r01 r11 r21 r02 r12 r22.
  typedef struct packed {
    logic             node;
    logic [2:0][15:0] scale;
    logic [2:0][31:0] trans;
    logic [8:0][33:0] rot;
  } rot_t;

  typedef struct packed {
    logic             node;
    logic [2:0][31:0] trans;
    logic [8:0][49:0] prod;
  } mul_t;

  typedef struct packed {
    logic              node;
    logic [11:0][31:0] m;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/quaternion_trs_to_matrix.sv =====
// An accepted transaction passes the quat_mul, rot_sum, scale_mul and round stage registers in order.
// One transaction per cycle when out_ready is high; the four pipeline registers hold one item each.
// Backpressure stalls only the stages that are full, so bubbles are squeezed out.
// Reset (rst, synchronous, active high) clears every stage valid bit; data is not reset.
`default_nettype none
`include "quaternion_trs_to_matrix_assert.svh"
module quaternion_trs_to_matrix (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               node_present,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  input  wire logic signed [15:0] quat_w,
  input  wire logic signed [15:0] scale_x,
  input  wire logic signed [15:0] scale_y,
  input  wire logic signed [15:0] scale_z,
  input  wire logic signed [31:0] trans_x,
  input  wire logic signed [31:0] trans_y,
  input  wire logic signed [31:0] trans_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      m00,
  output logic signed [31:0]      m10,
  output logic signed [31:0]      m20,
  output logic signed [31:0]      m01,
  output logic signed [31:0]      m11,
  output logic signed [31:0]      m21,
  output logic signed [31:0]      m02,
  output logic signed [31:0]      m12,
  output logic signed [31:0]      m22,
  output logic signed [31:0]      m03,
  output logic signed [31:0]      m13,
  output logic signed [31:0]      m23
);
  import qtm_pkg::*;

  // The pipeline runs in four stages:
  //   1. the nine quaternion products (16 by 16 bit multipliers),
  //   2. the rotation entries as exact sums in Q.28,
  //   3. each entry times the scale of its column (34 by 16 bit multipliers),
  //   4. rounding to Q15.16 and the identity substitution when no node is present.
  // Each stage is ready when it is empty or when the stage after it is ready.

  in_t   in_data;
  prod_t s1_data;
  rot_t  s2_data;
  mul_t  s3_data;
  res_t  s4_data;
  logic  s1_valid, s1_ready;
  logic  s2_valid, s2_ready;
  logic  s3_valid, s3_ready;

  always_comb begin
    in_data.node     = node_present;
    in_data.qx       = quat_x;
    in_data.qy       = quat_y;
    in_data.qz       = quat_z;
    in_data.qw       = quat_w;
    in_data.scale[0] = scale_x;
    in_data.scale[1] = scale_y;
    in_data.scale[2] = scale_z;
    in_data.trans[0] = trans_x;
    in_data.trans[1] = trans_y;
    in_data.trans[2] = trans_z;
  end

  qtm_quat_mul u_quat_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  qtm_rot_sum u_rot_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  qtm_scale_mul u_scale_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_data  (s3_data)
  );

  // The last stage register is the output register of the block.
  qtm_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_data   (s3_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (s4_data)
  );

  // Column-major outputs; the translation column is copied through unchanged when a node is present.
  assign m00 = s4_data.m[0];
  assign m10 = s4_data.m[1];
  assign m20 = s4_data.m[2];
  assign m01 = s4_data.m[3];
  assign m11 = s4_data.m[4];
  assign m21 = s4_data.m[5];
  assign m02 = s4_data.m[6];
  assign m12 = s4_data.m[7];
  assign m22 = s4_data.m[8];
  assign m03 = s4_data.m[9];
  assign m13 = s4_data.m[10];
  assign m23 = s4_data.m[11];

  // With the downstream side taking a transaction, the ready chain must reach the input.
  `QTM_ASSERT_IMPL(a_ready_chain, clk, rst, out_ready, in_ready)
  // A result for an absent node is the identity with a zero translation.
  `QTM_ASSERT_IMPL(a_identity, clk, rst, out_valid && !s4_data.node, (m00 == ONE_Q16) && (m11 == ONE_Q16) && (m22 == ONE_Q16) && (m10 == 32'sd0) && (m01 == 32'sd0) && (m03 == 32'sd0) && (m23 == 32'sd0))
  // Reset empties every stage of the pipeline.
  `QTM_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !s1_valid && !s2_valid && !s3_valid && !out_valid)

endmodule
`default_nettype wire

// ===== hw/rtl/qtm_quat_mul.sv =====
`default_nettype none
module qtm_quat_mul (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire qtm_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output qtm_pkg::prod_t     out_data
);
  import qtm_pkg::*;

  logic  valid;
  prod_t data;
  prod_t data_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  // The nine pairwise quaternion products, each exact at 28 fractional bits.
  always_comb begin
    data_next.node  = in_data.node;
    data_next.scale = in_data.scale;
    data_next.trans = in_data.trans;
    data_next.xx    = 32'(in_data.qx) * 32'(in_data.qx);
    data_next.yy    = 32'(in_data.qy) * 32'(in_data.qy);
    data_next.zz    = 32'(in_data.qz) * 32'(in_data.qz);
    data_next.xy    = 32'(in_data.qx) * 32'(in_data.qy);
    data_next.xz    = 32'(in_data.qx) * 32'(in_data.qz);
    data_next.yz    = 32'(in_data.qy) * 32'(in_data.qz);
    data_next.wx    = 32'(in_data.qw) * 32'(in_data.qx);
    data_next.wy    = 32'(in_data.qw) * 32'(in_data.qy);
    data_next.wz    = 32'(in_data.qw) * 32'(in_data.qz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/qtm_rot_sum.sv =====
`default_nettype none
module qtm_rot_sum (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire qtm_pkg::prod_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output qtm_pkg::rot_t       out_data
);
  import qtm_pkg::*;

  logic valid;
  rot_t data;
  rot_t data_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  // Doubled products need 33 bits and the sums 34; the sums stay within about 2^32 and are exact.
  always_comb begin
    logic signed [33:0] xx2, yy2, zz2, xy2, xz2, yz2, wx2, wy2, wz2;
    xx2 = 34'(in_data.xx) <<< 1;
    yy2 = 34'(in_data.yy) <<< 1;
    zz2 = 34'(in_data.zz) <<< 1;
    xy2 = 34'(in_data.xy) <<< 1;
    xz2 = 34'(in_data.xz) <<< 1;
    yz2 = 34'(in_data.yz) <<< 1;
    wx2 = 34'(in_data.wx) <<< 1;
    wy2 = 34'(in_data.wy) <<< 1;
    wz2 = 34'(in_data.wz) <<< 1;
    data_next.node   = in_data.node;
    data_next.scale  = in_data.scale;
    data_next.trans  = in_data.trans;
    data_next.rot[0] = ONE_Q28 - yy2 - zz2;
    data_next.rot[1] = xy2 + wz2;
    data_next.rot[2] = xz2 - wy2;
    data_next.rot[3] = xy2 - wz2;
    data_next.rot[4] = ONE_Q28 - xx2 - zz2;
    data_next.rot[5] = yz2 + wx2;
    data_next.rot[6] = xz2 + wy2;
    data_next.rot[7] = yz2 - wx2;
    data_next.rot[8] = ONE_Q28 - xx2 - yy2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/qtm_scale_mul.sv =====
`default_nettype none
module qtm_scale_mul (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire qtm_pkg::rot_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output qtm_pkg::mul_t      out_data
);
  import qtm_pkg::*;

  logic valid;
  mul_t data;
  mul_t data_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  // Nine 34 by 16 bit lanes; entry k belongs to column k / 3.
  always_comb begin
    logic signed [33:0] r;
    logic signed [15:0] s;
    logic signed [49:0] p;
    data_next.node  = in_data.node;
    data_next.trans = in_data.trans;
    for (int k = 0; k < 9; k++) begin
      r = $signed(in_data.rot[k]);
      s = $signed(in_data.scale[k / 3]);
      p = 50'(r) * 50'(s);
      data_next.prod[k] = p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/qtm_round.sv =====
`default_nettype none
module qtm_round (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire qtm_pkg::mul_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output qtm_pkg::res_t      out_data
);
  import qtm_pkg::*;

  logic valid;
  res_t data;
  res_t data_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  // Round half up, then floor shift. The products stay below 2^48 in magnitude,
  // so the shifted result is below 2^28 and always fits the 32-bit range.
  always_comb begin
    logic signed [49:0] v;
    logic signed [49:0] q;
    data_next.node = in_data.node;
    for (int k = 0; k < 9; k++) begin
      v = $signed(in_data.prod[k]) + RND_HALF;
      q = v >>> RND_SHIFT;
      data_next.m[k] = q[31:0];
    end
    for (int k = 0; k < 3; k++) begin
      data_next.m[9 + k] = in_data.trans[k];
    end
    if (!in_data.node) begin
      for (int k = 0; k < 12; k++) begin
        data_next.m[k] = '0;
      end
      data_next.m[0] = ONE_Q16;
      data_next.m[4] = ONE_Q16;
      data_next.m[8] = ONE_Q16;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule
`default_nettype wire
